// ===== design/cstsm_pkg.sv =====
package cstsm_pkg;

   localparam int SNR_WIDTH   = 16;
   localparam int PROB_WIDTH  = 16;
   localparam int CTX_WIDTH   = 3;
   localparam int SNR_FRAC    = 11;
   localparam int ROWS        = 3;
   localparam int LANES       = 4;
   localparam int REF_LANE    = 3;
   localparam int TERMS       = 12;
   localparam int ACC_WIDTH   = 32;
   localparam int U_WIDTH     = 30;
   localparam int G_WIDTH     = 30;
   localparam int K_WIDTH     = 6;
   localparam int TERM_WIDTH  = 31;
   localparam int SUM_WIDTH   = 33;
   localparam int E_WIDTH     = 31;
   localparam int RECIP_WIDTH = 35;
   localparam int RECIP_SHIFT = 34;
   localparam int K_RECIP_WIDTH = 13;
   localparam int K_SHIFT     = 36;

   localparam longint HSAT = 64'sd2147483647;
   localparam logic [G_WIDTH-1:0] LN2_Q30 = 30'd744261118;
   localparam logic [TERM_WIDTH-1:0] ONE_Q30 = 31'd1073741824;
   localparam logic signed [32:0] EXP_CUT = 33'sd536870912;
   localparam logic [K_RECIP_WIDTH-1:0] K_RECIP = 13'd5909;

   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   typedef struct packed {
      logic [CTX_WIDTH-1:0] context_code;
      logic [SNR_WIDTH-1:0] snr_chan_a;
      logic [SNR_WIDTH-1:0] snr_chan_c;
      logic [SNR_WIDTH-1:0] snr_chan_g;
      logic [SNR_WIDTH-1:0] snr_chan_t;
   } req_type;

   typedef struct packed {
      logic [PROB_WIDTH-1:0] match_prob;
      logic [PROB_WIDTH-1:0] second_prob;
      logic [PROB_WIDTH-1:0] third_prob;
      logic [PROB_WIDTH-1:0] fourth_prob;
   } rsp_type;

   typedef struct packed {
      logic                           valid;
      logic [ROWS-1:0][ACC_WIDTH-1:0] x;
   } cubic_type;

   typedef struct packed {
      logic                          valid;
      logic [LANES-1:0][G_WIDTH-1:0] g;
      logic [LANES-1:0][K_WIDTH-1:0] k;
      logic [LANES-1:0]              cut;
   } reduce_type;

   typedef struct packed {
      logic                          valid;
      logic [LANES-1:0][E_WIDTH-1:0] e;
   } taylor_type;

   function automatic logic signed [ACC_WIDTH-1:0] qc(input longint n);
      longint r;
      if (n < 0) begin
         r = (n * 64'sd16777216 - 64'sd500000000) / 64'sd1000000000;
      end else begin
         r = (n * 64'sd16777216 + 64'sd500000000) / 64'sd1000000000;
      end
      return ACC_WIDTH'(r);
   endfunction

   // [context][row][power], Q8.24
   localparam logic signed [ACC_WIDTH-1:0] COEF_ROM [8][3][4] = '{
      '{ '{qc(-64'sd3253480046), qc(64'sd109117296), qc(-64'sd4784071), qc(64'sd76823)},
         '{qc(-64'sd3238791571), qc(64'sd121188915), qc(-64'sd7157522), qc(64'sd160519)},
         '{qc(-64'sd689416151), qc(-64'sd466535536), qc(64'sd24542184), qc(-64'sd435458)} },
      '{ '{qc(-64'sd5205389472), qc(64'sd670790817), qc(-64'sd57413021), qc(64'sd1646296)},
         '{qc(-64'sd1586414914), qc(-64'sd178410808), qc(64'sd20802852), qc(-64'sd545250)},
         '{qc(64'sd940581728), qc(-64'sd996712716), qc(64'sd82995438), qc(-64'sd2399284)} },
      '{ '{qc(-64'sd3153983416), qc(64'sd2271055), qc(64'sd3754273), qc(-64'sd129379)},
         '{qc(-64'sd3070632970), qc(64'sd162919555), qc(-64'sd16805786), qc(64'sd507802)},
         '{qc(-64'sd201010193), qc(-64'sd577677766), qc(64'sd34076601), qc(-64'sd656804)} },
      '{ '{qc(-64'sd3699959230), qc(64'sd168892331), qc(-64'sd2305599), qc(-64'sd217584)},
         '{qc(-64'sd2307087026), qc(-64'sd2086559), qc(-64'sd1408042), qc(64'sd62327)},
         '{qc(64'sd676512170), qc(-64'sd888008929), qc(64'sd59126791), qc(-64'sd1377078)} },
      '{ '{qc(-64'sd2798945112), qc(64'sd80028360), qc(-64'sd3796366), qc(64'sd64942)},
         '{qc(-64'sd3241478842), qc(64'sd94531804), qc(-64'sd4717427), qc(64'sd93854)},
         '{qc(-64'sd146610215), qc(-64'sd470967914), qc(64'sd20441959), qc(-64'sd333016)} },
      '{ '{qc(-64'sd4910364933), qc(64'sd610796757), qc(-64'sd56900899), qc(64'sd1774640)},
         '{qc(-64'sd2488308653), qc(64'sd45683444), qc(-64'sd4288703), qc(64'sd276929)},
         '{qc(-64'sd2582097163), qc(-64'sd52148430), qc(-64'sd22563988), qc(64'sd1301233)} },
      '{ '{qc(-64'sd3459877449), qc(64'sd143922020), qc(-64'sd7939919), qc(64'sd199287)},
         '{qc(-64'sd2680828632), qc(64'sd4612035), qc(64'sd1400012), qc(-64'sd78444)},
         '{qc(-64'sd1340790465), qc(-64'sd291102282), qc(64'sd6397063), qc(64'sd23927)} },
      '{ '{qc(-64'sd5165866215), qc(64'sd645825450), qc(-64'sd57169869), qc(64'sd1658760)},
         '{qc(-64'sd2622356029), qc(-64'sd19022374), qc(64'sd5954991), qc(-64'sd253125)},
         '{qc(-64'sd1310892215), qc(-64'sd340095653), qc(64'sd17664849), qc(-64'sd473980)} }
   };

   // ceil(2^34 / n), exact quotient for 30-bit dividends
   localparam logic [RECIP_WIDTH-1:0] RECIP [1:TERMS] = '{
      RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'd0) / 64'd1),
      RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'd1) / 64'd2),
      RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3),
      RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'd3) / 64'd4),
      RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'd4) / 64'd5),
      RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6),
      RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'd6) / 64'd7),
      RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'd7) / 64'd8),
      RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'd8) / 64'd9),
      RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'd9) / 64'd10),
      RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'd10) / 64'd11),
      RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'd11) / 64'd12)
   };

endpackage

// ===== design/cstsm_cubic.sv =====
module cstsm_cubic (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  cstsm_pkg::req_type    in_req,
   output cstsm_pkg::cubic_type  out_x
);

   localparam int DEGREE = 3;

   logic [DEGREE:0] v_ff;
   logic [cstsm_pkg::CTX_WIDTH-1:0] ctx_ff [DEGREE];
   logic [cstsm_pkg::SNR_WIDTH-1:0] snr_ff [DEGREE];
   logic signed [cstsm_pkg::ACC_WIDTH-1:0] acc_ff [1:DEGREE][cstsm_pkg::ROWS];
   logic [cstsm_pkg::SNR_WIDTH-1:0] snr_sel;

   function automatic logic signed [cstsm_pkg::ACC_WIDTH-1:0] horner_step(
      input logic signed [cstsm_pkg::ACC_WIDTH-1:0] acc,
      input logic [cstsm_pkg::SNR_WIDTH-1:0]        snr,
      input logic signed [cstsm_pkg::ACC_WIDTH-1:0] c
   );
      logic signed [cstsm_pkg::ACC_WIDTH+cstsm_pkg::SNR_WIDTH:0] prod;
      logic signed [cstsm_pkg::ACC_WIDTH+cstsm_pkg::SNR_WIDTH-cstsm_pkg::SNR_FRAC:0] sh;
      logic signed [cstsm_pkg::ACC_WIDTH+cstsm_pkg::SNR_WIDTH-cstsm_pkg::SNR_FRAC+1:0] s;
      prod = acc * $signed({1'b0, snr});
      sh = $bits(sh)'(prod >>> cstsm_pkg::SNR_FRAC);
      s = $bits(s)'(sh) + $bits(s)'(c);
      if (s > cstsm_pkg::HSAT) begin
         return cstsm_pkg::ACC_WIDTH'(cstsm_pkg::HSAT);
      end else if (s < -cstsm_pkg::HSAT) begin
         return cstsm_pkg::ACC_WIDTH'(-cstsm_pkg::HSAT);
      end
      return cstsm_pkg::ACC_WIDTH'(s);
   endfunction

   always_comb begin
      unique case (in_req.context_code[1:0])
         cstsm_pkg::BASE_A: snr_sel = in_req.snr_chan_a;
         cstsm_pkg::BASE_C: snr_sel = in_req.snr_chan_c;
         cstsm_pkg::BASE_G: snr_sel = in_req.snr_chan_g;
         cstsm_pkg::BASE_T: snr_sel = in_req.snr_chan_t;
         default:           snr_sel = in_req.snr_chan_a;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[DEGREE-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff[0] <= in_req.context_code;
      snr_ff[0] <= snr_sel;
      for (int s = 1; s < DEGREE; s++) begin
         ctx_ff[s] <= ctx_ff[s-1];
         snr_ff[s] <= snr_ff[s-1];
      end
      for (int r = 0; r < cstsm_pkg::ROWS; r++) begin
         acc_ff[1][r] <= horner_step(cstsm_pkg::COEF_ROM[ctx_ff[0]][r][3], snr_ff[0],
                                     cstsm_pkg::COEF_ROM[ctx_ff[0]][r][2]);
         acc_ff[2][r] <= horner_step(acc_ff[1][r], snr_ff[1],
                                     cstsm_pkg::COEF_ROM[ctx_ff[1]][r][1]);
         acc_ff[3][r] <= horner_step(acc_ff[2][r], snr_ff[2],
                                     cstsm_pkg::COEF_ROM[ctx_ff[2]][r][0]);
      end
   end

   always_comb begin
      out_x.valid = v_ff[DEGREE];
      for (int r = 0; r < cstsm_pkg::ROWS; r++) begin
         out_x.x[r] = acc_ff[DEGREE][r];
      end
   end

endmodule

// ===== design/cstsm_reduce.sv =====
module cstsm_reduce (
   input  logic                   clock,
   input  logic                   reset,
   input  cstsm_pkg::cubic_type   in_x,
   output cstsm_pkg::reduce_type  out_r
);

   localparam int L = cstsm_pkg::LANES;
   localparam int KP_WIDTH = cstsm_pkg::U_WIDTH + cstsm_pkg::K_RECIP_WIDTH;
   localparam int G0_WIDTH = cstsm_pkg::G_WIDTH + 1;
   localparam int U30_WIDTH = cstsm_pkg::U_WIDTH + 6;

   logic [5:1] v_ff;
   logic signed [cstsm_pkg::ACC_WIDTH-1:0] x_ff [cstsm_pkg::ROWS];
   logic signed [cstsm_pkg::ACC_WIDTH-1:0] m_ff;
   logic signed [cstsm_pkg::ACC_WIDTH-1:0] m_in;
   logic signed [32:0] d_in [L];
   logic [cstsm_pkg::U_WIDTH-1:0] u2_ff [L];
   logic [cstsm_pkg::U_WIDTH-1:0] u3_ff [L];
   logic [L-1:0] cut2_ff, cut3_ff, cut4_ff, cut5_ff;
   logic [KP_WIDTH-1:0] kp_ff [L];
   logic [cstsm_pkg::K_WIDTH-1:0] kest_in [L];
   logic [cstsm_pkg::K_WIDTH-1:0] k4_ff [L];
   logic [cstsm_pkg::K_WIDTH-1:0] k5_ff [L];
   logic [G0_WIDTH-1:0] g4_ff [L];
   logic [cstsm_pkg::G_WIDTH-1:0] g5_ff [L];

   always_comb begin
      m_in = '0;
      for (int r = 0; r < cstsm_pkg::ROWS; r++) begin
         if ($signed(in_x.x[r]) > m_in) begin
            m_in = $signed(in_x.x[r]);
         end
      end
   end

   always_comb begin
      for (int r = 0; r < cstsm_pkg::ROWS; r++) begin
         d_in[r] = 33'(m_ff) - 33'(x_ff[r]);
      end
      d_in[cstsm_pkg::REF_LANE] = 33'(m_ff);
      for (int l = 0; l < L; l++) begin
         kest_in[l] = kp_ff[l][cstsm_pkg::K_SHIFT +: cstsm_pkg::K_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[4:1], in_x.valid};
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in;
      for (int r = 0; r < cstsm_pkg::ROWS; r++) begin
         x_ff[r] <= $signed(in_x.x[r]);
      end
      for (int l = 0; l < L; l++) begin
         cut2_ff[l] <= d_in[l] > cstsm_pkg::EXP_CUT;
         u2_ff[l]   <= (d_in[l] > cstsm_pkg::EXP_CUT) ? '0 : d_in[l][cstsm_pkg::U_WIDTH-1:0];
         kp_ff[l]   <= KP_WIDTH'(u2_ff[l]) * KP_WIDTH'(cstsm_pkg::K_RECIP);
         u3_ff[l]   <= u2_ff[l];
         k4_ff[l]   <= kest_in[l];
         g4_ff[l]   <= G0_WIDTH'({u3_ff[l], 6'b0}
                       - U30_WIDTH'(kest_in[l]) * U30_WIDTH'(cstsm_pkg::LN2_Q30));
         if (g4_ff[l] >= G0_WIDTH'(cstsm_pkg::LN2_Q30)) begin
            g5_ff[l] <= cstsm_pkg::G_WIDTH'(g4_ff[l] - G0_WIDTH'(cstsm_pkg::LN2_Q30));
            k5_ff[l] <= k4_ff[l] + 1'b1;
         end else begin
            g5_ff[l] <= cstsm_pkg::G_WIDTH'(g4_ff[l]);
            k5_ff[l] <= k4_ff[l];
         end
      end
      cut3_ff <= cut2_ff;
      cut4_ff <= cut3_ff;
      cut5_ff <= cut4_ff;
   end

   always_comb begin
      out_r.valid = v_ff[5];
      out_r.cut   = cut5_ff;
      for (int l = 0; l < L; l++) begin
         out_r.g[l] = g5_ff[l];
         out_r.k[l] = k5_ff[l];
      end
   end

endmodule

// ===== design/cstsm_taylor.sv =====
module cstsm_taylor (
   input  logic                   clock,
   input  logic                   reset,
   input  cstsm_pkg::reduce_type  in_r,
   output cstsm_pkg::taylor_type  out_e
);

   localparam int L = cstsm_pkg::LANES;
   localparam int N = cstsm_pkg::TERMS;
   localparam int STG = 2 * N;
   localparam int GW = cstsm_pkg::G_WIDTH;
   localparam int PW = cstsm_pkg::TERM_WIDTH + GW + 1;
   localparam int QW = GW + cstsm_pkg::RECIP_WIDTH;

   logic [STG+1:0] v_ff;
   logic [GW-1:0] g_ff [0:STG-2][L];
   logic [cstsm_pkg::K_WIDTH-1:0] k_ff [0:STG][L];
   logic [L-1:0] cut_ff [0:STG];
   logic [cstsm_pkg::TERM_WIDTH-1:0] term_ff [0:N][L];
   logic signed [cstsm_pkg::SUM_WIDTH-1:0] sum_ff [0:N][L];
   logic signed [cstsm_pkg::SUM_WIDTH-1:0] suma_ff [1:N][L];
   logic [GW-1:0] prod_ff [1:N][L];
   logic [cstsm_pkg::E_WIDTH-1:0] e_ff [L];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[STG:0], in_r.valid};
      end
   end

   always_ff @(posedge clock) begin
      cut_ff[0] <= in_r.cut;
      for (int l = 0; l < L; l++) begin
         g_ff[0][l]    <= in_r.g[l];
         k_ff[0][l]    <= in_r.k[l];
         term_ff[0][l] <= cstsm_pkg::ONE_Q30;
         sum_ff[0][l]  <= $signed(cstsm_pkg::SUM_WIDTH'(cstsm_pkg::ONE_Q30));
      end
      for (int s = 1; s <= STG; s++) begin
         cut_ff[s] <= cut_ff[s-1];
         for (int l = 0; l < L; l++) begin
            k_ff[s][l] <= k_ff[s-1][l];
         end
      end
      for (int s = 1; s <= STG - 2; s++) begin
         for (int l = 0; l < L; l++) begin
            g_ff[s][l] <= g_ff[s-1][l];
         end
      end
      for (int l = 0; l < L; l++) begin
         if (cut_ff[STG][l] || sum_ff[N][l] < 0) begin
            e_ff[l] <= '0;
         end else begin
            e_ff[l] <= cstsm_pkg::E_WIDTH'(sum_ff[N][l]) >> k_ff[STG][l];
         end
      end
   end

   genvar n;
   for (n = 1; n <= N; n++) begin : g_term
      logic [GW-1:0] q_in [L];

      always_comb begin
         for (int l = 0; l < L; l++) begin
            q_in[l] = GW'((QW'(prod_ff[n][l]) * QW'(cstsm_pkg::RECIP[n]))
                      >> cstsm_pkg::RECIP_SHIFT);
         end
      end

      always_ff @(posedge clock) begin
         for (int l = 0; l < L; l++) begin
            prod_ff[n][l] <= GW'((PW'(term_ff[n-1][l]) * PW'(g_ff[2*n-2][l])) >> 30);
            suma_ff[n][l] <= sum_ff[n-1][l];
            term_ff[n][l] <= cstsm_pkg::TERM_WIDTH'(q_in[l]);
            if ((n % 2) == 1) begin
               sum_ff[n][l] <= suma_ff[n][l] - $signed(cstsm_pkg::SUM_WIDTH'(q_in[l]));
            end else begin
               sum_ff[n][l] <= suma_ff[n][l] + $signed(cstsm_pkg::SUM_WIDTH'(q_in[l]));
            end
         end
      end
   end

   always_comb begin
      out_e.valid = v_ff[STG+1];
      for (int l = 0; l < L; l++) begin
         out_e.e[l] = e_ff[l];
      end
   end

endmodule

// ===== design/cstsm_divide.sv =====
module cstsm_divide (
   input  logic                   clock,
   input  logic                   reset,
   input  cstsm_pkg::taylor_type  in_e,
   output logic                   out_valid,
   output cstsm_pkg::rsp_type     out_rsp
);

   localparam int L  = cstsm_pkg::LANES;
   localparam int PB = cstsm_pkg::PROB_WIDTH;
   localparam int QB = PB + 1;
   localparam int EW = cstsm_pkg::E_WIDTH;
   localparam int DW = EW + 2;
   localparam int NW = EW + PB + 1;

   logic [QB+2:0] v_ff;
   logic [EW-1:0] e1_ff [L];
   logic [DW-1:0] sum1_ff;
   logic [DW-1:0] sum_in;
   logic [NW-1:0] n_ff [0:QB-1][L];
   logic [DW-1:0] d_ff [0:QB-1];
   logic [DW-1:0] r_ff [1:QB][L];
   logic [QB-1:0] q_ff [1:QB][L];
   logic [PB-1:0] p_in [L];
   cstsm_pkg::rsp_type rsp_ff;

   always_comb begin
      sum_in = '0;
      for (int l = 0; l < L; l++) begin
         sum_in = sum_in + DW'(in_e.e[l]);
      end
      for (int l = 0; l < L; l++) begin
         p_in[l] = q_ff[QB][l][PB] ? '1 : q_ff[QB][l][PB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[QB+1:0], in_e.valid};
      end
   end

   always_ff @(posedge clock) begin
      sum1_ff  <= sum_in;
      d_ff[0]  <= sum1_ff;
      for (int l = 0; l < L; l++) begin
         e1_ff[l]   <= in_e.e[l];
         n_ff[0][l] <= NW'({e1_ff[l], {PB{1'b0}}}) + NW'(sum1_ff >> 1);
      end
      for (int s = 1; s < QB; s++) begin
         d_ff[s] <= d_ff[s-1];
         for (int l = 0; l < L; l++) begin
            n_ff[s][l] <= n_ff[s-1][l];
         end
      end
      rsp_ff.match_prob  <= p_in[cstsm_pkg::REF_LANE];
      rsp_ff.second_prob <= p_in[1];
      rsp_ff.third_prob  <= p_in[0];
      rsp_ff.fourth_prob <= p_in[2];
   end

   genvar i;
   for (i = 0; i < QB; i++) begin : g_bit
      logic [DW-1:0] rp_in [L];
      logic [QB-1:0] qp_in [L];
      logic [DW:0]   t_in  [L];

      if (i == 0) begin : g_head
         always_comb begin
            for (int l = 0; l < L; l++) begin
               rp_in[l] = DW'(n_ff[0][l] >> QB);
               qp_in[l] = '0;
            end
         end
      end else begin : g_tail
         always_comb begin
            for (int l = 0; l < L; l++) begin
               rp_in[l] = r_ff[i][l];
               qp_in[l] = q_ff[i][l];
            end
         end
      end

      always_comb begin
         for (int l = 0; l < L; l++) begin
            t_in[l] = {rp_in[l], n_ff[i][l][QB-1-i]};
         end
      end

      always_ff @(posedge clock) begin
         for (int l = 0; l < L; l++) begin
            if (t_in[l] >= {1'b0, d_ff[i]}) begin
               r_ff[i+1][l] <= DW'(t_in[l] - {1'b0, d_ff[i]});
               q_ff[i+1][l] <= qp_in[l] | (QB'(1) << (QB - 1 - i));
            end else begin
               r_ff[i+1][l] <= DW'(t_in[l]);
               q_ff[i+1][l] <= qp_in[l];
            end
         end
      end
   end

   assign out_valid = v_ff[QB+2];
   assign out_rsp   = rsp_ff;

endmodule

// ===== design/context_snr_transition_softmax_top.sv =====
// channel   ports                        transfer when
// request   start, busy, req_data        rising edge with start high and busy low
// result    rsp_valid, rsp_data          every cycle rsp_valid is high (one cycle)
//
// Fully pipelined: one request per cycle, with a result strobe for each accepted
// request; the exp series uses 12 terms and the divider is 17-bit.
// busy stays low; results cannot be held off, so the pipeline never stalls.
// reset (synchronous) clears all valid bits; items in flight are dropped.
module context_snr_transition_softmax_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  cstsm_pkg::req_type  req_data,
   output logic                rsp_valid,
   output cstsm_pkg::rsp_type  rsp_data
);

   cstsm_pkg::cubic_type  cubic;
   cstsm_pkg::reduce_type reduced;
   cstsm_pkg::taylor_type expo;
   logic                  in_valid;

   assign busy     = 1'b0;
   assign in_valid = start & ~busy;

   cstsm_cubic u_cubic (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .in_req   (req_data),
      .out_x    (cubic)
   );

   cstsm_reduce u_reduce (
      .clock (clock),
      .reset (reset),
      .in_x  (cubic),
      .out_r (reduced)
   );

   cstsm_taylor u_taylor (
      .clock (clock),
      .reset (reset),
      .in_r  (reduced),
      .out_e (expo)
   );

   cstsm_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_e      (expo),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

endmodule
